### rtl/core/fsa_pkg.sv
// Shared widths, command codes and status codes of the free-list slot allocator.
package fsa_pkg;

    localparam int DEF_CAPACITY = 1024;

    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 11;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_RELEASE    = 2'd1,
        CMD_POOL_RESET = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_EMPTY   = 3'd1,
        STATUS_NULL    = 3'd2,
        STATUS_OUTSIDE = 3'd3,
        STATUS_DOUBLE  = 3'd4
    } status_t;

endpackage

### rtl/core/fsa_if.sv
// Request and response channel interfaces of the free-list slot allocator.
interface fsa_req_if
    import fsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] handle;
    logic                handle_present;

    modport source (output valid, output command, output handle, output handle_present,
                    input ready);
    modport sink   (input valid, input command, input handle, input handle_present,
                    output ready);
endinterface

interface fsa_rsp_if
    import fsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output slot, output status, input ready);
    modport sink   (input valid, input slot, input status, output ready);
endinterface

### rtl/core/fsa_slot_mem.sv
// Slot table RAM: one write port, one read port with registered read data.
module fsa_slot_mem
    import fsa_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int AW    = $clog2(DEF_CAPACITY),
    parameter int DW    = $clog2(DEF_CAPACITY + 1) + 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read entry into the registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/free_list_slot_allocator.sv
// Top level of the free-list slot allocator: control, head register and result register.
//
//  channel | role   | word fields                        | accepted when
//  --------+--------+------------------------------------+-------------------
//  req     | sink   | command, handle, handle_present    | req.valid & ready
//  rsp     | source | slot, status                       | rsp.valid & ready
//
// Allocate and release do a slot-table read, then the table write-back with
// the head update; the single RAM port pair keeps these steps apart.
// A pool reset command, and rst_n, start a relink pass over all CAPACITY
// slot-table entries (one entry a cycle); req.ready stays low during it.
// A result waits in the output register while the next word is taken; a word
// finishing while that register is still full holds until rsp drains.
module free_list_slot_allocator
    import fsa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    fsa_req_if.sink   req,
    fsa_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int DW = LW + 1;
    localparam int XW = (LW > HANDLE_W) ? LW : HANDLE_W;
    localparam int SX = (LW > SLOT_W) ? LW : SLOT_W;

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic                  present_reg, present_next;
    logic                  outside_reg, outside_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [LW-1:0]         head_reg, head_next;
    logic [AW-1:0]         sweep_reg, sweep_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]     rsp_slot_reg, rsp_slot_next;
    status_t               rsp_status_reg, rsp_status_next;

    logic                  accept;
    logic                  out_free;
    logic [XW-1:0]         handle_x;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic                  entry_used;
    logic [LW-1:0]         entry_link;
    logic [SX-1:0]         head_x;

    // Slot table: {in-use bit, next link}
    fsa_slot_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign handle_x   = XW'(req.handle);
    assign entry_used = rd_data[LW];
    assign entry_link = rd_data[LW-1:0];
    assign head_x     = SX'(head_reg);

    // Read the head entry for allocate, the handle entry otherwise
    always_comb
    begin
        if (req.command == CMD_ALLOC)
        begin
            rd_addr = head_reg[AW-1:0];
        end
        else
        begin
            rd_addr = handle_x[AW-1:0];
        end
    end

    // Sequence sweep, accept and write-back
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        present_next    = present_reg;
        outside_next    = outside_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        sweep_next      = sweep_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_slot_next   = rsp_slot_reg;
        rsp_status_next = rsp_status_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {1'b0, head_reg};

        unique case (state_reg)
            ST_SWEEP:
            begin
                // Relink entry i to i+1 and mark it free
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {1'b0, LW'(sweep_reg) + LW'(1)};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = req.command;
                    present_next = req.handle_present;
                    outside_next = (handle_x >= XW'(CAPACITY));
                    idx_next     = rd_addr;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_slot_next   = '0;
                    rsp_status_next = STATUS_OK;
                    state_next      = ST_IDLE;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            if (head_reg == LW'(CAPACITY))
                            begin
                                rsp_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // Pop the head, mark it used
                                rsp_slot_next = head_x[SLOT_W-1:0];
                                head_next     = entry_link;
                                wr_en         = 1'b1;
                                wr_data       = {1'b1, entry_link};
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (!present_reg)
                            begin
                                rsp_status_next = STATUS_NULL;
                            end
                            else if (outside_reg)
                            begin
                                rsp_status_next = STATUS_OUTSIDE;
                            end
                            else if (!entry_used)
                            begin
                                rsp_status_next = STATUS_DOUBLE;
                            end
                            else
                            begin
                                // Push the slot onto the list
                                head_next = LW'(idx_reg);
                                wr_en     = 1'b1;
                                wr_data   = {1'b0, head_reg};
                            end
                        end
                        CMD_POOL_RESET:
                        begin
                            head_next  = '0;
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            rsp_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            head_reg      <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Held word and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        present_reg    <= present_next;
        outside_reg    <= outside_next;
        idx_reg        <= idx_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.slot   = rsp_slot_reg;
    assign rsp.status = rsp_status_reg;

endmodule

### tb/sv/fsa_pool_checker.sv
`timescale 1ns / 1ps
// Checker of the free-list slot allocator: mirrors the pool and compares every response word.
module fsa_pool_checker
    import fsa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    fsa_req_if   req,
    fsa_rsp_if   rsp,
    output int   mismatches,
    output int   expected_left
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } pool_result_t;

    // Mirror of the pool: successor links, head of the free list, in-use bits
    logic [HANDLE_W-1:0] link_mem [CAPACITY];
    logic [HANDLE_W-1:0] free_head;
    logic                in_use   [CAPACITY];

    pool_result_t awaited_rsp [$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Free every slot and chain them in index order
    task automatic relink_pool();
        for (int i = 0; i < CAPACITY; i++)
        begin
            link_mem[i] = HANDLE_W'(i + 1);
            in_use[i]   = 1'b0;
        end
        free_head = '0;
    endtask

    // Apply one request word to the mirror and return the response it earns
    task automatic model_pool_word(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h,
                                   input logic present, output pool_result_t res);
        logic [HANDLE_W-1:0] taken;
        res.slot   = '0;
        res.status = STATUS_OK;
        case (cmd)
            CMD_ALLOC:
            begin
                if (int'(free_head) >= CAPACITY)
                    res.status = STATUS_EMPTY;
                else
                begin
                    taken         = free_head;
                    res.slot      = taken[SLOT_W-1:0];
                    free_head     = link_mem[taken];
                    in_use[taken] = 1'b1;
                end
            end
            CMD_RELEASE:
            begin
                if (!present)
                    res.status = STATUS_NULL;
                else if (int'(h) >= CAPACITY)
                    res.status = STATUS_OUTSIDE;
                else if (!in_use[h])
                    res.status = STATUS_DOUBLE;
                else
                begin
                    in_use[h]   = 1'b0;
                    link_mem[h] = free_head;
                    free_head   = h;
                end
            end
            CMD_POOL_RESET:
                relink_pool();
            default: ;
        endcase
    endtask

    initial
    begin
        mismatches    = 0;
        expected_left = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t got_res;
        pool_result_t want_res;
        if (!rst_n)
        begin
            relink_pool();
            awaited_rsp.delete();
            expected_left <= 0;
        end
        else
        begin
            // Compare a response word against the oldest expectation
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                    report_mismatch($sformatf("response slot=%0d status=%0d with none expected",
                                              rsp.slot, rsp.status));
                else
                begin
                    want_res = awaited_rsp.pop_front();
                    if (rsp.slot !== want_res.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  rsp.slot, want_res.slot));
                    if (rsp.status !== want_res.status)
                        report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                                  rsp.status, want_res.status,
                                                  want_res.status.name()));
                end
            end
            // Predict the response of an accepted request word
            if (req.valid && req.ready)
            begin
                model_pool_word(req.command, req.handle, req.handle_present, got_res);
                awaited_rsp.push_back(got_res);
            end
            expected_left <= awaited_rsp.size();
        end
    end

endmodule

### tb/sv/tb_free_list_slot_allocator.sv
`timescale 1ns / 1ps
// Top of the free-list slot allocator testbench: clock, reset, request stimulus and verdict.
module tb_free_list_slot_allocator;
    import fsa_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_WORDS = 112;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   expected_left;
    int   send_idle_pct;
    int   rsp_stall_pct;

    // Slots seen granted on the response side, used to build legal releases
    logic [SLOT_W-1:0] granted_slots [$];

    fsa_req_if req_ch ();
    fsa_rsp_if rsp_ch ();

    free_list_slot_allocator #(.CAPACITY(CAPACITY)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    fsa_pool_checker #(.CAPACITY(CAPACITY)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the response side at the current rate
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Collect granted slots other than slot 0
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STATUS_OK
            && rsp_ch.slot != '0)
            granted_slots.push_back(rsp_ch.slot);
    end

    // Offer one word, hold it until taken, then maybe idle
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h,
                             input logic present);
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.handle         <= h;
        req_ch.handle_present <= present;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.command        <= CMD_W'($urandom_range(3));
            req_ch.handle         <= HANDLE_W'($urandom_range(2047));
            req_ch.handle_present <= 1'($urandom_range(1));
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold off the sender until every expected response has come
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
    endtask

    task automatic send_random_word();
        int pick;
        int idx;
        logic [HANDLE_W-1:0] h;
        pick = $urandom_range(99);
        h    = HANDLE_W'($urandom_range(2047));
        if (pick < 45)
            send_word(CMD_ALLOC, h, 1'($urandom_range(1)));
        else if (pick < 80)
        begin
            // Release a slot known to be granted, else any slot in the pool
            if (granted_slots.size() != 0)
            begin
                idx = $urandom_range(granted_slots.size() - 1);
                h   = HANDLE_W'(granted_slots[idx]);
                granted_slots.delete(idx);
            end
            else
                h = HANDLE_W'($urandom_range(CAPACITY - 1));
            send_word(CMD_RELEASE, h, 1'b1);
        end
        else if (pick < 88)
            send_word(CMD_RELEASE, h, 1'b1);
        else if (pick < 92)
            send_word(CMD_RELEASE, h, 1'b0);
        else if (pick < 95)
            send_word(CMD_RELEASE, HANDLE_W'($urandom_range(2047, CAPACITY)), 1'b1);
        else if (pick < 97)
        begin
            granted_slots.delete();
            send_word(CMD_POOL_RESET, h, 1'($urandom_range(1)));
        end
        else
            send_word(CMD_UNUSED, h, 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.command        <= CMD_ALLOC;
        req_ch.handle         <= '0;
        req_ch.handle_present <= 1'b0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: grants, every release check, ignored fields, unused code, pool reset
        send_word(CMD_ALLOC, 11'd2047, 1'b1);
        send_word(CMD_ALLOC, 11'd0, 1'b0);
        send_word(CMD_RELEASE, 11'd0, 1'b0);
        send_word(CMD_RELEASE, 11'd2047, 1'b0);
        send_word(CMD_RELEASE, 11'd2047, 1'b1);
        send_word(CMD_RELEASE, 11'd1024, 1'b1);
        send_word(CMD_RELEASE, 11'd1023, 1'b1);
        send_word(CMD_RELEASE, 11'd0, 1'b1);
        send_word(CMD_RELEASE, 11'd0, 1'b1);
        send_word(CMD_ALLOC, 11'd1365, 1'b1);
        send_word(CMD_UNUSED, 11'd2047, 1'b1);
        send_word(CMD_POOL_RESET, 11'd1234, 1'b1);
        send_word(CMD_ALLOC, 11'd682, 1'b0);
        send_word(CMD_RELEASE, 11'd1, 1'b1);
        wait_all_results();
        granted_slots.delete();

        // Random: one phase per idle pattern, drained between phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct = 33;
                    rsp_stall_pct = 33;
                end
            endcase
            repeat (PHASE_WORDS)
                send_random_word();
            wait_all_results();
        end

        // Let any trailing relink pass finish before the verdict
        repeat (CAPACITY + 16) @(posedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
